@@ rtl/core/ppc_pkg.sv @@
// shared types and constants of the polygon plane clipper
`timescale 1ns / 1ps
package ppc_pkg;

	localparam int MAX_VERTS = 16;
	localparam int IW        = $clog2(MAX_VERTS);
	localparam int CW        = $clog2(MAX_VERTS + 1);
	localparam int DW        = 52;
	localparam int ENTRY_W   = 3 * 32 + DW + 2;
	localparam int DIV_STEPS = 31;
	localparam int DCW       = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [2:0] CFG_NX  = 3'd0;
	localparam logic [2:0] CFG_NY  = 3'd1;
	localparam logic [2:0] CFG_NZ  = 3'd2;
	localparam logic [2:0] CFG_PD  = 3'd3;
	localparam logic [2:0] CFG_TOL = 3'd4;

	// multiplier operand selection for the distance dot product
	localparam logic [1:0] MSEL_X = 2'd0;
	localparam logic [1:0] MSEL_Y = 2'd1;
	localparam logic [1:0] MSEL_Z = 2'd2;

	typedef enum logic [1:0] {
		SD_FRONT = 2'd0,
		SD_BACK  = 2'd1,
		SD_ON    = 2'd2
	} side_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_STORE,
		ST_CLOSE,
		ST_EMPTY,
		ST_RD_FIRST,
		ST_LAT_FIRST,
		ST_RD_NEXT,
		ST_LAT_NEXT,
		ST_KEEP,
		ST_DIV_INIT,
		ST_DIV,
		ST_LERP_MUL,
		ST_LERP_ADD,
		ST_PUT_SPLIT,
		ST_ADVANCE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       latch;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       acc_init;
		logic       acc_add;
		logic       store;
		logic       put_marker;
		logic       rd;
		logic       rd_first;
		logic       lat_cur;
		logic       lat_nxt;
		logic       put_cur;
		logic       div_init;
		logic       div_step;
		logic       lerp_mul;
		logic       lerp_add;
		logic       put_split;
		logic       advance;
		logic       flush;
		logic       clear;
	} cmd_t;

	typedef struct packed {
		logic last_vtx;
		logic empty_case;
		logic keep;
		logic split;
		logic div_done;
		logic coord_done;
		logic idx_last;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/ppc_if.sv @@
// vertex and result channel interfaces
`timescale 1ns / 1ps
interface ppc_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic signed [31:0] vertex_z;
	logic               last_vertex;
	modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface ppc_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               empty_result;
	logic               last_out;
	modport source (output valid, out_x, out_y, out_z, empty_result, last_out, input ready);
	modport sink (input valid, out_x, out_y, out_z, empty_result, last_out, output ready);
endinterface

@@ rtl/core/ppc_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ppc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/core/ppc_ctrl.sv @@
// sequencing state machine of the polygon plane clipper
`timescale 1ns / 1ps
module ppc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ppc_pkg::sts_t sts,
	output ppc_pkg::cmd_t cmd
);
	ppc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppc_pkg::ST_IDLE:      if (in_valid) state_d = ppc_pkg::ST_MUL0;
			ppc_pkg::ST_MUL0:      state_d = ppc_pkg::ST_MUL1;
			ppc_pkg::ST_MUL1:      state_d = ppc_pkg::ST_MUL2;
			ppc_pkg::ST_MUL2:      state_d = ppc_pkg::ST_ACC;
			ppc_pkg::ST_ACC:       state_d = ppc_pkg::ST_STORE;
			ppc_pkg::ST_STORE:
				state_d = sts.last_vtx ? ppc_pkg::ST_CLOSE : ppc_pkg::ST_IDLE;
			ppc_pkg::ST_CLOSE:
				state_d = sts.empty_case ? ppc_pkg::ST_EMPTY : ppc_pkg::ST_RD_FIRST;
			ppc_pkg::ST_EMPTY:     if (sts.out_free) state_d = ppc_pkg::ST_IDLE;
			ppc_pkg::ST_RD_FIRST:  state_d = ppc_pkg::ST_LAT_FIRST;
			ppc_pkg::ST_LAT_FIRST: state_d = ppc_pkg::ST_RD_NEXT;
			ppc_pkg::ST_RD_NEXT:   state_d = ppc_pkg::ST_LAT_NEXT;
			ppc_pkg::ST_LAT_NEXT:  state_d = ppc_pkg::ST_KEEP;
			ppc_pkg::ST_KEEP: begin
				if (!sts.keep || sts.out_free) begin
					state_d = sts.split ? ppc_pkg::ST_DIV_INIT : ppc_pkg::ST_ADVANCE;
				end
			end
			ppc_pkg::ST_DIV_INIT:  state_d = ppc_pkg::ST_DIV;
			ppc_pkg::ST_DIV:       if (sts.div_done) state_d = ppc_pkg::ST_LERP_MUL;
			ppc_pkg::ST_LERP_MUL:  state_d = ppc_pkg::ST_LERP_ADD;
			ppc_pkg::ST_LERP_ADD:
				state_d = sts.coord_done ? ppc_pkg::ST_PUT_SPLIT : ppc_pkg::ST_LERP_MUL;
			ppc_pkg::ST_PUT_SPLIT: if (sts.out_free) state_d = ppc_pkg::ST_ADVANCE;
			ppc_pkg::ST_ADVANCE:
				state_d = sts.idx_last ? ppc_pkg::ST_FINISH : ppc_pkg::ST_RD_NEXT;
			ppc_pkg::ST_FINISH:    if (sts.out_free) state_d = ppc_pkg::ST_IDLE;
			default:               state_d = ppc_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ppc_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ppc_pkg::ST_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ppc_pkg::MSEL_X;
			end
			ppc_pkg::ST_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = ppc_pkg::MSEL_Y;
				cmd.acc_init = 1'b1;
			end
			ppc_pkg::ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ppc_pkg::MSEL_Z;
				cmd.acc_add = 1'b1;
			end
			ppc_pkg::ST_ACC:       cmd.acc_add = 1'b1;
			ppc_pkg::ST_STORE:     cmd.store = 1'b1;
			ppc_pkg::ST_CLOSE:     cmd = '0;
			ppc_pkg::ST_EMPTY: begin
				cmd.put_marker = sts.out_free;
				cmd.clear      = sts.out_free;
			end
			ppc_pkg::ST_RD_FIRST: begin
				cmd.rd       = 1'b1;
				cmd.rd_first = 1'b1;
			end
			ppc_pkg::ST_LAT_FIRST: cmd.lat_cur = 1'b1;
			ppc_pkg::ST_RD_NEXT:   cmd.rd = 1'b1;
			ppc_pkg::ST_LAT_NEXT:  cmd.lat_nxt = 1'b1;
			ppc_pkg::ST_KEEP:      cmd.put_cur = sts.keep && sts.out_free;
			ppc_pkg::ST_DIV_INIT:  cmd.div_init = 1'b1;
			ppc_pkg::ST_DIV:       cmd.div_step = 1'b1;
			ppc_pkg::ST_LERP_MUL:  cmd.lerp_mul = 1'b1;
			ppc_pkg::ST_LERP_ADD:  cmd.lerp_add = 1'b1;
			ppc_pkg::ST_PUT_SPLIT: cmd.put_split = sts.out_free;
			ppc_pkg::ST_ADVANCE:   cmd.advance = 1'b1;
			ppc_pkg::ST_FINISH: begin
				cmd.flush = sts.out_free;
				cmd.clear = sts.out_free;
			end
			default:               cmd = '0;
		endcase
	end
endmodule

@@ rtl/core/ppc_dp.sv @@
// datapath: plane distance, vertex store, split division, interpolation, output
`timescale 1ns / 1ps
module ppc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic               in_last,
	input  ppc_pkg::cmd_t      cmd,
	output ppc_pkg::sts_t      sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               out_empty,
	output logic               out_last
);
	localparam int DW = ppc_pkg::DW;
	localparam int IW = ppc_pkg::IW;
	localparam int CW = ppc_pkg::CW;

	// configuration registers
	logic signed [31:0] nx_q, ny_q, nz_q, pd_q;
	logic [30:0]        tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= 32'sd65536;
			pd_q  <= '0;
			tol_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppc_pkg::CFG_NX:  nx_q  <= cfg_wdata;
				ppc_pkg::CFG_NY:  ny_q  <= cfg_wdata;
				ppc_pkg::CFG_NZ:  nz_q  <= cfg_wdata;
				ppc_pkg::CFG_PD:  pd_q  <= cfg_wdata;
				ppc_pkg::CFG_TOL: tol_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// input vertex latch
	logic signed [31:0] x_q, y_q, z_q;
	logic               last_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			x_q    <= in_x;
			y_q    <= in_y;
			z_q    <= in_z;
			last_q <= in_last;
		end
	end

	// dot product: one multiply per cycle, floored to q16.16 and accumulated
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod_q;
	logic signed [DW-1:0] acc_q, pfl, pd_ext;

	always_comb begin
		case (cmd.mul_sel)
			ppc_pkg::MSEL_X: begin ma = x_q; mb = nx_q; end
			ppc_pkg::MSEL_Y: begin ma = y_q; mb = ny_q; end
			default:         begin ma = z_q; mb = nz_q; end
		endcase
	end

	assign pfl    = {{(DW - 48){prod_q[63]}}, prod_q[63:16]};
	assign pd_ext = {{(DW - 32){pd_q[31]}}, pd_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= ma * mb;
		end
		if (cmd.acc_init) begin
			acc_q <= pfl - pd_ext;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + pfl;
		end
	end

	// side classification against the tolerance band
	logic signed [DW-1:0] tol_ext;
	ppc_pkg::side_t       side;

	assign tol_ext = {{(DW - 31){1'b0}}, tol_q};

	always_comb begin
		if (acc_q > tol_ext) begin
			side = ppc_pkg::SD_FRONT;
		end else if (acc_q < -tol_ext) begin
			side = ppc_pkg::SD_BACK;
		end else begin
			side = ppc_pkg::SD_ON;
		end
	end

	// polygon counters and walk index
	logic [CW-1:0] cnt_q;
	logic          any_back_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] idx_inc;
	logic [IW-1:0] nxt_idx;
	logic          can_store;

	assign can_store = cnt_q < CW'(ppc_pkg::MAX_VERTS);
	assign idx_inc   = {{(CW - IW){1'b0}}, idx_q} + CW'(1);
	assign nxt_idx   = (idx_inc == cnt_q) ? '0 : idx_inc[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			any_back_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (cmd.clear) begin
				cnt_q      <= '0;
				any_back_q <= 1'b0;
			end else if (cmd.store && can_store) begin
				cnt_q <= cnt_q + CW'(1);
				if (side == ppc_pkg::SD_BACK) begin
					any_back_q <= 1'b1;
				end
			end
			if (cmd.rd_first) begin
				idx_q <= '0;
			end else if (cmd.advance) begin
				idx_q <= idx_inc[IW-1:0];
			end
		end
	end

	// vertex store
	logic [ppc_pkg::ENTRY_W-1:0] wdata, rdata;

	assign wdata = {x_q, y_q, z_q, acc_q, side};

	ppc_ram #(
		.WIDTH(ppc_pkg::ENTRY_W),
		.DEPTH(ppc_pkg::MAX_VERTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.store && can_store),
		.waddr(cnt_q[IW-1:0]),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(cmd.rd_first ? '0 : nxt_idx),
		.rdata(rdata)
	);

	// current and next vertex of the edge being walked
	logic signed [31:0]   cx_q, cy_q, cz_q, nxx_q, nxy_q, nxz_q;
	logic signed [DW-1:0] cd_q, nd_q;
	ppc_pkg::side_t       cs_q, ns_q;

	always_ff @(posedge clk) begin
		if (cmd.lat_cur) begin
			{cx_q, cy_q, cz_q, cd_q} <= rdata[ppc_pkg::ENTRY_W-1:2];
			cs_q <= ppc_pkg::side_t'(rdata[1:0]);
		end else if (cmd.advance) begin
			{cx_q, cy_q, cz_q, cd_q} <= {nxx_q, nxy_q, nxz_q, nd_q};
			cs_q <= ns_q;
		end
		if (cmd.lat_nxt) begin
			{nxx_q, nxy_q, nxz_q, nd_q} <= rdata[ppc_pkg::ENTRY_W-1:2];
			ns_q <= ppc_pkg::side_t'(rdata[1:0]);
		end
	end

	// split fraction: restoring division, one quotient bit a cycle
	logic [DW-1:0]    num;
	logic signed [DW:0] diff;
	logic [DW:0]      den;
	logic [DW+1:0]    rem_q, rem2;
	logic [30:0]      quo_q;
	logic [ppc_pkg::DCW-1:0] dcnt_q;

	assign num  = cd_q[DW-1] ? DW'(-cd_q) : DW'(cd_q);
	assign diff = {cd_q[DW-1], cd_q} - {nd_q[DW-1], nd_q};
	assign den  = diff[DW] ? (DW + 1)'(-diff) : (DW + 1)'(diff);
	assign rem2 = {rem_q[DW:0], 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= {2'b00, num};
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + ppc_pkg::DCW'(1);
			if (rem2 >= {1'b0, den}) begin
				rem_q <= rem2 - {1'b0, den};
				quo_q <= {quo_q[29:0], 1'b1};
			end else begin
				rem_q <= rem2;
				quo_q <= {quo_q[29:0], 1'b0};
			end
		end
	end

	// interpolation: one coordinate at a time, multiply then add
	logic [1:0]         crd_q;
	logic signed [31:0] la, lb;
	logic signed [32:0] delta;
	logic [32:0]        mag;
	logic [63:0]        lprod_q;
	logic               lneg_q;
	logic [32:0]        lsum;
	logic signed [31:0] spx_q, spy_q, spz_q;

	always_comb begin
		case (crd_q)
			2'd0:    begin la = cx_q; lb = nxx_q; end
			2'd1:    begin la = cy_q; lb = nxy_q; end
			default: begin la = cz_q; lb = nxz_q; end
		endcase
	end

	assign delta = {lb[31], lb} - {la[31], la};
	assign mag   = delta[32] ? 33'(-delta) : 33'(delta);
	assign lsum  = lneg_q ? ({la[31], la} - lprod_q[63:31]) : ({la[31], la} + lprod_q[63:31]);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			crd_q <= '0;
		end else if (cmd.lerp_add) begin
			crd_q <= crd_q + 2'd1;
		end
		if (cmd.lerp_mul) begin
			lprod_q <= 64'(mag * {2'b00, quo_q});
			lneg_q  <= delta[32];
		end
		if (cmd.lerp_add) begin
			case (crd_q)
				2'd0:    spx_q <= lsum[31:0];
				2'd1:    spy_q <= lsum[31:0];
				default: spz_q <= lsum[31:0];
			endcase
		end
	end

	// one-deep pending slot so the final result can carry last_out
	logic               pend_v_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic               put;
	logic signed [31:0] nx_item, ny_item, nz_item;
	logic               ov_q;

	assign put     = cmd.put_cur || cmd.put_split;
	assign nx_item = cmd.put_split ? spx_q : cx_q;
	assign ny_item = cmd.put_split ? spy_q : cy_q;
	assign nz_item = cmd.put_split ? spz_q : cz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (put) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (cmd.put_marker || cmd.flush || (put && pend_v_q)) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (put) begin
			px_q <= nx_item;
			py_q <= ny_item;
			pz_q <= nz_item;
		end
		if (cmd.put_marker) begin
			out_x     <= '0;
			out_y     <= '0;
			out_z     <= '0;
			out_empty <= 1'b1;
			out_last  <= 1'b1;
		end else if (cmd.flush || (put && pend_v_q)) begin
			out_x     <= px_q;
			out_y     <= py_q;
			out_z     <= pz_q;
			out_empty <= 1'b0;
			out_last  <= cmd.flush;
		end
	end

	assign out_valid = ov_q;

	// status to the controller
	always_comb begin
		sts.last_vtx   = last_q;
		sts.empty_case = (cnt_q >= CW'(ppc_pkg::MAX_VERTS - 1)) || !any_back_q;
		sts.keep       = cs_q != ppc_pkg::SD_FRONT;
		sts.split      = (cs_q != ppc_pkg::SD_ON) && (ns_q != ppc_pkg::SD_ON)
		                 && (cs_q != ns_q);
		sts.div_done   = dcnt_q == ppc_pkg::DCW'(ppc_pkg::DIV_STEPS - 1);
		sts.coord_done = crd_q == 2'd2;
		sts.idx_last   = idx_inc == cnt_q;
		sts.out_free   = !ov_q || out_ready;
	end
endmodule

@@ rtl/core/polygon_plane_clipper_top.sv @@
// top level of the single plane polygon clipper
`timescale 1ns / 1ps
// Vertices enter on the vtx channel, one transaction each, last_vertex on the
// closing one. Clipped vertices leave on the res channel; last_out marks the
// final one, and a polygon with nothing behind the plane (or 15 or more
// vertices) gives one transaction with empty_result set.
// Each vertex is loaded in turn: the plane distance is a dot product computed
// on one shared 32x32 multiplier (MUL0, MUL1, MUL2, ACC), then stored.
// After the closing vertex the store is walked edge by edge through its
// single read port; each split point adds a restoring division and the
// three interpolation multiplies.
// The empty marker is registered from the EMPTY state, after CLOSE, once the output is free.
// One polygon is processed at a time; vtx.ready is low during the walk.
// Reset clears the counters, the controller and the output valid flag and loads
// the default plane (normal along +z through the origin, zero tolerance).
// A stalled receiver holds the result register and the walk waits for it.
// Configuration is written through cfg_we, cfg_index, cfg_wdata.
module polygon_plane_clipper_top (
	input  logic        clk,
	input  logic        arst_n,
	ppc_vtx_if.sink     vtx,
	ppc_res_if.source   res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	ppc_pkg::cmd_t cmd;
	ppc_pkg::sts_t sts;
	logic          in_ready;

	assign vtx.ready = in_ready;

	ppc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(vtx.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ppc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_x     (vtx.vertex_x),
		.in_y     (vtx.vertex_y),
		.in_z     (vtx.vertex_z),
		.in_last  (vtx.last_vertex),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.out_x    (res.out_x),
		.out_y    (res.out_y),
		.out_z    (res.out_z),
		.out_empty(res.empty_result),
		.out_last (res.last_out)
	);

`ifndef SYNTH
	// an empty marker is always the final transaction of its polygon
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.empty_result |-> res.last_out)
		else $error("empty marker without last_out");

	// the empty marker carries zero coordinates (x and z are checked)
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.empty_result |-> res.out_x == 0 && res.out_z == 0)
		else $error("empty marker with nonzero coordinates");

	// a vertex transaction starts the distance computation, no back-to-back accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		vtx.valid && vtx.ready |=> !vtx.ready)
		else $error("vertex accepted during computation");
`endif
endmodule

@@ tb/sv/tb_polygon_plane_clipper_top.sv @@
// self-checking testbench of the single plane polygon clipper
`timescale 1ns / 1ps
module tb_polygon_plane_clipper_top;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        empty;
		logic        last;
	} clip_vtx_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
		logic        marker;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	ppc_vtx_if vtx();
	ppc_res_if res();

	polygon_plane_clipper_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// plane model state
	longint nrm_x, nrm_y, nrm_z, pl_off, tol;
	longint pos_mem [ppc_pkg::MAX_VERTS][3];
	longint dist_mem [ppc_pkg::MAX_VERTS];
	ppc_pkg::side_t side_mem [ppc_pkg::MAX_VERTS];
	int     n_verts, n_front, n_back;
	bit     too_many;

	clip_vtx_t clipped_q[$];
	int        errors;
	bit        quiet;
	bit        hold_req;
	bit        feeding;
	dir_row_t  dir_tab[15];

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint unsigned split_frac(longint d1, longint d2);
		longint diff;
		longint unsigned num, den, q, r;
		diff = d1 - d2;
		num = d1 < 0 ? -d1 : d1;
		den = diff < 0 ? -diff : diff;
		q = 0;
		r = num;
		if (den == 0)
			return 0;
		if (num >= den)
			return 64'd1 << 31;
		for (int b = 0; b < 31; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic longint interp(longint a, longint b, longint unsigned t);
		longint delta;
		longint unsigned mag, off;
		delta = b - a;
		mag = delta < 0 ? -delta : delta;
		off = (mag * t) >> 31;
		return delta < 0 ? a - longint'(off) : a + longint'(off);
	endfunction

	function automatic clip_vtx_t mk_vtx(longint x, longint y, longint z);
		clip_vtx_t v;
		v.x = x[31:0];
		v.y = y[31:0];
		v.z = z[31:0];
		v.empty = 1'b0;
		v.last = 1'b0;
		return v;
	endfunction

	function automatic clip_vtx_t empty_marker();
		clip_vtx_t v;
		v.x = '0;
		v.y = '0;
		v.z = '0;
		v.empty = 1'b1;
		v.last = 1'b1;
		return v;
	endfunction

	// expected clipped vertices for one accepted vertex
	task automatic clip_predict(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
			logic lst);
		longint x, y, z, d;
		longint unsigned t;
		ppc_pkg::side_t s, s1, s2;
		int j, k0;
		x = longint'(signed'(vx));
		y = longint'(signed'(vy));
		z = longint'(signed'(vz));
		d = ((x * nrm_x) >>> 16) + ((y * nrm_y) >>> 16) + ((z * nrm_z) >>> 16) - pl_off;
		if (d > tol)
			s = ppc_pkg::SD_FRONT;
		else if (d < -tol)
			s = ppc_pkg::SD_BACK;
		else
			s = ppc_pkg::SD_ON;
		if (n_verts < ppc_pkg::MAX_VERTS) begin
			pos_mem[n_verts][0] = x;
			pos_mem[n_verts][1] = y;
			pos_mem[n_verts][2] = z;
			dist_mem[n_verts] = d;
			side_mem[n_verts] = s;
			n_verts++;
			if (s == ppc_pkg::SD_FRONT)
				n_front++;
			else if (s == ppc_pkg::SD_BACK)
				n_back++;
		end else begin
			too_many = 1'b1;
		end
		if (lst) begin
			if (too_many || n_verts >= ppc_pkg::MAX_VERTS - 1 || n_back == 0) begin
				clipped_q.push_back(empty_marker());
			end else begin
				k0 = clipped_q.size();
				for (int i = 0; i < n_verts; i++) begin
					j = (i + 1 == n_verts) ? 0 : i + 1;
					s1 = side_mem[i];
					s2 = side_mem[j];
					if (n_front == 0 || s1 != ppc_pkg::SD_FRONT)
						clipped_q.push_back(mk_vtx(pos_mem[i][0], pos_mem[i][1],
							pos_mem[i][2]));
					if (n_front != 0 && s1 != ppc_pkg::SD_ON && s2 != ppc_pkg::SD_ON
							&& s1 != s2) begin
						t = split_frac(dist_mem[i], dist_mem[j]);
						clipped_q.push_back(mk_vtx(interp(pos_mem[i][0], pos_mem[j][0], t),
							interp(pos_mem[i][1], pos_mem[j][1], t),
							interp(pos_mem[i][2], pos_mem[j][2], t)));
					end
				end
				if (clipped_q.size() > k0)
					clipped_q[clipped_q.size() - 1].last = 1'b1;
			end
			n_verts = 0;
			n_front = 0;
			n_back = 0;
			too_many = 1'b0;
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			ppc_pkg::CFG_NX:  nrm_x = longint'(signed'(val));
			ppc_pkg::CFG_NY:  nrm_y = longint'(signed'(val));
			ppc_pkg::CFG_NZ:  nrm_z = longint'(signed'(val));
			ppc_pkg::CFG_PD:  pl_off = longint'(signed'(val));
			ppc_pkg::CFG_TOL: tol = longint'(val[30:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
			logic [31:0] pd, logic [31:0] tl);
		write_reg(ppc_pkg::CFG_NX, nx);
		write_reg(ppc_pkg::CFG_NY, ny);
		write_reg(ppc_pkg::CFG_NZ, nz);
		write_reg(ppc_pkg::CFG_PD, pd);
		write_reg(ppc_pkg::CFG_TOL, tl);
	endtask

	// wait until every expected vertex is out and the walk has wound down
	task automatic drain();
		while (clipped_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// one vertex transaction; drops valid first when a gap is drawn
	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic lst,
			bit marker);
		int gap, k0;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 13);
			vtx.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		vtx.valid = 1'b1;
		vtx.vertex_x = x;
		vtx.vertex_y = y;
		vtx.vertex_z = z;
		vtx.last_vertex = lst;
		do
			@(posedge clk);
		while (!vtx.ready);
		k0 = clipped_q.size();
		clip_predict(x, y, z, lst);
		if (marker) begin
			while (clipped_q.size() > k0)
				void'(clipped_q.pop_back());
			clipped_q.push_back(empty_marker());
		end
	endtask

	task automatic stop_feed();
		@(negedge clk);
		vtx.valid = 1'b0;
	endtask

	function automatic logic [31:0] rnd_coord(int mode);
		if (mode == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	function automatic logic [31:0] rnd_norm();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'sd0;
			default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		endcase
	endfunction

	task automatic rnd_polygon();
		int nv, mode;
		nv = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 7);
		mode = $urandom_range(0, 3);
		for (int i = 0; i < nv; i++)
			send_vertex(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), i == nv - 1, 1'b0);
	endtask

	// result checker
	always @(posedge clk) begin
		clip_vtx_t e;
		if (arst_n && res.valid && res.ready) begin
			if (clipped_q.size() == 0) begin
				$display("%0t: unexpected result transaction x=%h y=%h z=%h e=%b l=%b",
					$time, res.out_x, res.out_y, res.out_z, res.empty_result,
					res.last_out);
				errors++;
			end else begin
				e = clipped_q.pop_front();
				if (res.out_x !== e.x || res.out_y !== e.y || res.out_z !== e.z ||
						res.empty_result !== e.empty || res.last_out !== e.last) begin
					$display("%0t: mismatch expected x=%h y=%h z=%h e=%b l=%b",
						$time, e.x, e.y, e.z, e.empty, e.last);
					$display("%0t:          actual   x=%h y=%h z=%h e=%b l=%b",
						$time, res.out_x, res.out_y, res.out_z, res.empty_result,
						res.last_out);
					errors++;
				end
			end
		end
	end

	// receiver: random ready bursts, one long hold-off on request
	initial begin
		int cnt;
		bit on;
		cnt = 0;
		on = 1'b1;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res.ready = 1'b0;
				repeat (400) @(negedge clk);
				cnt = 0;
			end
			if (quiet) begin
				res.ready = 1'b1;
			end else begin
				if (cnt == 0) begin
					on = ($urandom_range(0, 2) != 0);
					cnt = $urandom_range(1, 13);
				end
				cnt--;
				res.ready = on;
			end
		end
	end

	// stimulus
	initial begin
		errors = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ppc_pkg::CFG_NX;
		cfg_wdata = '0;
		vtx.valid = 1'b0;
		vtx.vertex_x = '0;
		vtx.vertex_y = '0;
		vtx.vertex_z = '0;
		vtx.last_vertex = 1'b0;
		nrm_x = 0;
		nrm_y = 0;
		nrm_z = 65536;
		pl_off = 0;
		tol = 0;
		n_verts = 0;
		n_front = 0;
		n_back = 0;
		too_many = 1'b0;

		// default plane z = 0: distance equals z
		dir_tab = '{
			// all in front: empty marker
			'{32'd0, 32'd0, 32'd1, 1'b0, 1'b0},
			'{32'd1, 32'd0, 32'd5, 1'b0, 1'b0},
			'{32'd0, 32'd1, 32'd3, 1'b1, 1'b1},
			// all behind, extreme coordinates: copied
			'{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b0},
			'{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
			'{32'd0, 32'd0, 32'hffff_fffb, 1'b1, 1'b0},
			// straddling triangle: two split points
			'{32'd0, 32'd0, 32'hffff_0000, 1'b0, 1'b0},
			'{32'h0001_0000, 32'd0, 32'h0001_0000, 1'b0, 1'b0},
			'{32'd0, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0},
			// on-plane vertex never splits
			'{32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
			'{32'd10, 32'd0, 32'hffff_fff6, 1'b0, 1'b0},
			'{32'd0, 32'd10, 32'd10, 1'b1, 1'b0},
			// single vertex behind
			'{32'd5, 32'd5, 32'hffff_ffff, 1'b1, 1'b0},
			// all on the plane: empty marker
			'{32'd7, 32'd9, 32'd0, 1'b0, 1'b0},
			'{32'hffff_fff0, 32'd3, 32'd0, 1'b1, 1'b1}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows at the reset plane
		foreach (dir_tab[i])
			send_vertex(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].last,
				dir_tab[i].marker);
		// oversized polygon behind the plane
		for (int i = 0; i < 17; i++)
			send_vertex(i, -i, -100 - i, i == 16, 1'b0);
		stop_feed();
		drain();

		// extreme plane settings
		set_plane(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		rnd_polygon();
		rnd_polygon();
		stop_feed();
		drain();
		set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
		rnd_polygon();
		rnd_polygon();
		stop_feed();
		drain();

		// random planes; one long receiver hold-off, quiet last phase
		for (int ph = 0; ph < 6; ph++) begin
			set_plane(rnd_norm(), rnd_norm(), rnd_norm(),
				($urandom_range(0, 3) == 0) ? $urandom
					: 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
				($urandom_range(0, 5) == 0) ? $urandom
					: ($urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 14)) : 32'd0));
			if (ph == 2)
				hold_req = 1'b1;
			if (ph == 5)
				quiet = 1'b1;
			for (int p = 0; p < 2; p++)
				rnd_polygon();
			stop_feed();
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/ppc_pkg.sv
rtl/core/ppc_if.sv
rtl/core/ppc_ram.sv
rtl/core/ppc_ctrl.sv
rtl/core/ppc_dp.sv
rtl/core/polygon_plane_clipper_top.sv
tb/sv/tb_polygon_plane_clipper_top.sv
